[hdl/pose_angle_axis_error_assert.svh]
// Assertion macros for the pose angle-axis error block.
// Expects signals named clock and reset in the module that uses them.
`ifndef POSE_ANGLE_AXIS_ERROR_ASSERT_SVH
`define POSE_ANGLE_AXIS_ERROR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PAE_ASSERT_IMP(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PAE_ASSERT_NXT(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error(msg);

`endif

[hdl/pae_pkg.sv]
// Shared types, constants and elaboration-time functions for the pose error block.
// No dependencies.
package pae_pkg;

   localparam int FRAC = 16;
   localparam int ROT_W = 18;
   localparam int POS_W = 32;
   localparam int ANG_W = 19;

   localparam logic signed [63:0] PI_Q61 = 64'sd7244019458077122842;

   typedef enum logic [1:0] {
      BR_GENERAL = 2'd0,
      BR_ALIGNED = 2'd1,
      BR_HALF    = 2'd2
   } branch_type;

   typedef enum logic [2:0] {
      REG_ROT_ROW0 = 3'd0,
      REG_ROT_ROW1 = 3'd1,
      REG_ROT_ROW2 = 3'd2,
      REG_POS_X    = 3'd3,
      REG_POS_Y    = 3'd4,
      REG_POS_Z    = 3'd5
   } csr_index_type;

   // Side payload that rides along the sqrt, CORDIC and divide stages.
   typedef struct packed {
      branch_type           branch;
      logic [2:0][18:0]     rot_half;
      logic [2:0][21:0]     skew;
      logic [27:0]          cx;
   } side_type;

   // Shift-subtract divide, used only to build constant tables.
   function automatic logic [63:0] pae_udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] rem;
      q = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in Q61 from the truncated power series.
   function automatic logic signed [63:0] pae_atan_q61(input int i);
      logic signed [63:0] sum;
      logic [63:0] term;
      int d;
      sum = '0;
      if (i == 0) begin
         return PI_Q61 >>> 2;
      end
      for (int k = 0; k < 32; k++) begin
         d = i * (2 * k + 1);
         if (d <= 61) begin
            term = pae_udiv(64'd1 << (61 - d), 64'(2 * k + 1));
            if (k % 2 == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
      end
      return sum;
   endfunction

endpackage

[hdl/pose_angle_axis_error.sv]
// Pose error between a streamed current pose and a configured target pose.
// Depends on pae_pkg and pose_angle_axis_error_assert.svh.
//
// One pose beat in, one error beat out, one beat per clock sustained while the output
// is not stalled. The pipe has 79 register stages: five stages of matrix product,
// skew, trace, squares and branch, 26 stages of a one-bit-per-stage square root, one
// pre-rotation and 24 CORDIC vectoring stages for atan2, three stages of angle
// rounding, product and magnitude, 19 stages of a one-quotient-bit-per-stage divider
// (three lanes, one per axis) and the output register. The whole pipe advances as one
// when the output register is empty or taken; a stall freezes every stage in place.
// Position error is target minus current, saturated. Rotation error is the
// angle-axis vector of Rt * Rc^T in Q3.16; rsp_tuser tells which case produced it
// (general atan2, aligned zero, or half-turn diagonal). Target registers take
// effect on the next accepted pose. The user must write them only while the pipe
// is empty; the block itself does not enforce this.
`include "pose_angle_axis_error_assert.svh"

module pose_angle_axis_error
   import pae_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // csr
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [53:0]  csr_wdata,
   // pose in
   input  logic         req_tvalid,
   output logic         req_tready,
   // lsb up: cur_r00..cur_r22 (9 x 18), cur_px, cur_py, cur_pz (3 x 32), pad 6
   input  logic [263:0] req_tdata,
   // error out
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // lsb up: pos_err_x, pos_err_y, pos_err_z (3 x 32), rot_err_x/y/z (3 x 19), pad 7
   output logic [159:0] rsp_tdata,
   // lsb up: branch_taken (2)
   output logic [1:0]   rsp_tuser
);

   localparam int SQRT_W   = 52;
   localparam int SQRT_N   = SQRT_W / 2;
   localparam int CORDIC_N = FRAC + 8;
   localparam int QW       = ANG_W;
   localparam int DV_W     = 46;
   localparam int POS_LSB  = 9 * ROT_W;

   localparam int ST_PROD = 0;
   localparam int ST_RMAT = 1;
   localparam int ST_SKEW = 2;
   localparam int ST_SQR  = 3;
   localparam int ST_LSQ  = 4;
   localparam int ST_CROT = ST_LSQ + SQRT_N + 1;
   localparam int ST_ANG  = ST_CROT + CORDIC_N + 1;
   localparam int ST_MUL  = ST_ANG + 1;
   localparam int ST_MAG  = ST_MUL + 1;
   localparam int ST_OUT  = ST_MAG + QW + 1;
   localparam int NST     = ST_OUT + 1;

   localparam logic signed [22:0] ONE_Q   = 23'sd1 <<< FRAC;
   localparam logic signed [25:0] HP_Q    = 26'(PI_Q61 >>> (54 - FRAC));
   localparam logic signed [63:0] PI_HALF = PI_Q61 >>> 1;

   // ---------------------------------------------------------------- csr
   logic [53:0]        rot_row_ff [3];
   logic signed [31:0] tpos_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_ff[0] <= 54'({ONE_Q[17:0], 36'd0});
         rot_row_ff[1] <= 54'({18'd0, ONE_Q[17:0], 18'd0});
         rot_row_ff[2] <= 54'({36'd0, ONE_Q[17:0]});
         for (int i = 0; i < 3; i++) tpos_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_ROT_ROW0: rot_row_ff[0] <= csr_wdata;
            REG_ROT_ROW1: rot_row_ff[1] <= csr_wdata;
            REG_ROT_ROW2: rot_row_ff[2] <= csr_wdata;
            REG_POS_X:    tpos_ff[0] <= csr_wdata[31:0];
            REG_POS_Y:    tpos_ff[1] <= csr_wdata[31:0];
            REG_POS_Z:    tpos_ff[2] <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow
   // One enable for the whole pipe: advance when the output slot frees up.
   logic             en;
   logic [NST-1:0]   vld_ff;

   assign en         = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   // ---------------------------------------------------------------- unpack
   logic signed [17:0] cur_m [3][3];
   logic signed [17:0] tgt_m [3][3];
   logic signed [32:0] pdif [3];
   logic [2:0][31:0]   pe_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            cur_m[i][k] = $signed(req_tdata[ROT_W*(3*i+k) +: ROT_W]);
            tgt_m[i][k] = $signed(rot_row_ff[i][36-18*k +: 18]);
         end
         pdif[i] = 33'(tpos_ff[i]) - 33'($signed(req_tdata[POS_LSB+POS_W*i +: POS_W]));
         // clamp target minus current to 32 bits
         if (pdif[i][32] != pdif[i][31]) begin
            pe_in[i] = pdif[i][32] ? 32'h8000_0000 : 32'h7fff_ffff;
         end else begin
            pe_in[i] = pdif[i][31:0];
         end
      end
   end

   // position error rides a plain shift line to the output
   logic [2:0][31:0] pe_ff [0:ST_OUT];

   // ---------------------------------------------------------------- R = Rt * Rc^T
   logic signed [35:0] prod_ff [3][3][3];
   logic signed [37:0] rsum [3][3];
   logic signed [21:0] r_ff [3][3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               for (int k = 0; k < 3; k++)
                  prod_ff[i][j][k] <= tgt_m[i][k] * cur_m[j][k];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            // round half up to FRAC bits
            rsum[i][j] = prod_ff[i][j][0] + prod_ff[i][j][1] + prod_ff[i][j][2]
                       + 38'sd32768;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               r_ff[i][j] <= rsum[i][j][37:16];
      end
   end

   // ---------------------------------------------------------------- skew, trace
   logic signed [21:0] skew_ff [3];
   logic signed [22:0] tr_ff;
   logic signed [21:0] dg_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         skew_ff[0] <= r_ff[2][1] - r_ff[1][2];
         skew_ff[1] <= r_ff[0][2] - r_ff[2][0];
         skew_ff[2] <= r_ff[1][0] - r_ff[0][1];
         tr_ff      <= 23'(r_ff[0][0]) + 23'(r_ff[1][1]) + 23'(r_ff[2][2]);
         for (int i = 0; i < 3; i++) dg_ff[i] <= r_ff[i][i];
      end
   end

   // ---------------------------------------------------------------- squares, half-turn
   logic signed [43:0] sqp [3];
   logic [41:0]        sq_ff [3];
   logic               zero_ff;
   logic signed [47:0] hp_ff [3];
   logic signed [22:0] tr3_ff;
   logic [2:0][21:0]   skew3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) sqp[i] = skew_ff[i] * skew_ff[i];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]    <= sqp[i][41:0];
            hp_ff[i]    <= HP_Q * (23'(dg_ff[i]) + ONE_Q);
            skew3_ff[i] <= skew_ff[i];
         end
         // |l| below 1e-6 at this scale means every skew entry is zero
         zero_ff <= (skew_ff[0] == '0) && (skew_ff[1] == '0) && (skew_ff[2] == '0);
         tr3_ff  <= tr_ff;
      end
   end

   // ---------------------------------------------------------------- lsq, branch
   side_type           side_ff [ST_LSQ:ST_OUT-1];
   side_type           side_lsq;
   logic [42:0]        lsq;
   logic signed [47:0] hpr [3];
   logic signed [23:0] trm;

   logic [52:0] sq_rem_ff  [0:SQRT_N];
   logic [52:0] sq_root_ff [0:SQRT_N];

   always_comb begin
      lsq = 43'(sq_ff[0]) + 43'(sq_ff[1]) + 43'(sq_ff[2]);
      trm = 24'(tr3_ff) - 24'(ONE_Q);
      side_lsq.skew = skew3_ff;
      side_lsq.cx   = {trm, 4'd0};
      for (int i = 0; i < 3; i++) begin
         hpr[i] = hp_ff[i] + 48'sd8388608;
         // clamp the rounded half-turn term into the Q3.16 field
         if (hpr[i][47:42] == {6{hpr[i][47]}}) begin
            side_lsq.rot_half[i] = hpr[i][42:24];
         end else begin
            side_lsq.rot_half[i] = hpr[i][47] ? 19'h40000 : 19'h3ffff;
         end
      end
      if (!zero_ff) begin
         side_lsq.branch = BR_GENERAL;
      end else if (tr3_ff > 0) begin
         side_lsq.branch = BR_ALIGNED;
      end else begin
         side_lsq.branch = BR_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[ST_LSQ] <= side_lsq;
         sq_rem_ff[0]    <= 53'({lsq, 8'd0});
         sq_root_ff[0]   <= '0;
      end
   end

   // ---------------------------------------------------------------- norm: isqrt
   // One result bit per stage; a fixed top trial bit gives the same root.
   for (genvar g = 0; g < SQRT_N; g++) begin : g_sqrt
      localparam logic [52:0] BIT = 53'd1 << (SQRT_W - 2 - 2 * g);
      logic [52:0] trial;
      assign trial = sq_root_ff[g] + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (sq_rem_ff[g] >= trial) begin
               sq_rem_ff[g+1]  <= sq_rem_ff[g] - trial;
               sq_root_ff[g+1] <= (sq_root_ff[g] >> 1) + BIT;
            end else begin
               sq_rem_ff[g+1]  <= sq_rem_ff[g];
               sq_root_ff[g+1] <= sq_root_ff[g] >> 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- atan2: CORDIC
   logic [25:0]        nrm_ff [ST_CROT:ST_OUT-1];
   logic [25:0]        nrm_in;
   logic signed [29:0] cd_x_ff [0:CORDIC_N];
   logic signed [29:0] cd_y_ff [0:CORDIC_N];
   logic signed [63:0] cd_z_ff [0:CORDIC_N];
   logic signed [27:0] cx_in;

   assign nrm_in = sq_root_ff[SQRT_N][25:0];
   assign cx_in  = $signed(side_ff[ST_CROT-1].cx);

   always_ff @(posedge clock) begin
      if (en) begin
         nrm_ff[ST_CROT] <= nrm_in;
         // left half plane: pre-rotate by a quarter turn
         if (cx_in < 0) begin
            cd_x_ff[0] <= 30'(nrm_in);
            cd_y_ff[0] <= -30'(cx_in);
            cd_z_ff[0] <= PI_HALF;
         end else begin
            cd_x_ff[0] <= 30'(cx_in);
            cd_y_ff[0] <= 30'(nrm_in);
            cd_z_ff[0] <= '0;
         end
      end
   end

   for (genvar g = 0; g < CORDIC_N; g++) begin : g_cordic
      localparam logic signed [63:0] ATAN = pae_atan_q61(g);
      always_ff @(posedge clock) begin
         if (en) begin
            if (cd_y_ff[g] > 0) begin
               cd_x_ff[g+1] <= cd_x_ff[g] + (cd_y_ff[g] >>> g);
               cd_y_ff[g+1] <= cd_y_ff[g] - (cd_x_ff[g] >>> g);
               cd_z_ff[g+1] <= cd_z_ff[g] + ATAN;
            end else begin
               cd_x_ff[g+1] <= cd_x_ff[g] - (cd_y_ff[g] >>> g);
               cd_y_ff[g+1] <= cd_y_ff[g] + (cd_x_ff[g] >>> g);
               cd_z_ff[g+1] <= cd_z_ff[g] - ATAN;
            end
         end
      end
   end

   // ---------------------------------------------------------------- angle * l / norm
   logic signed [63:0] zr;
   logic signed [22:0] ang_ff;
   logic signed [44:0] p_ff [3];
   logic [44:0]        pabs [3];
   logic [DV_W-1:0]    dv_rem_ff [0:QW][3];
   logic [QW-1:0]      dv_q_ff   [0:QW][3];
   logic               dv_neg_ff [0:QW][3];

   assign zr = cd_z_ff[CORDIC_N] + (64'sd1 <<< (60 - FRAC - 4));

   always_comb begin
      for (int i = 0; i < 3; i++) pabs[i] = p_ff[i][44] ? 45'(-p_ff[i]) : 45'(p_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= zr[63:41];
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= ang_ff * $signed(side_ff[ST_MUL-1].skew[i]);
            // round to nearest, ties away from zero, on the magnitude
            dv_rem_ff[0][i] <= DV_W'(pabs[i]) + DV_W'(nrm_ff[ST_MAG-1] >> 1);
            dv_q_ff[0][i]   <= '0;
            dv_neg_ff[0][i] <= p_ff[i][44];
         end
      end
   end

   // restoring divide, one quotient bit per stage, three lanes
   for (genvar g = 0; g < QW; g++) begin : g_div
      localparam logic [QW-1:0] QBIT = QW'(1) << (QW - 1 - g);
      logic [DV_W-1:0] den;
      assign den = DV_W'(nrm_ff[ST_MAG+g]) << (QW - 1 - g);
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               dv_neg_ff[g+1][i] <= dv_neg_ff[g][i];
               if (dv_rem_ff[g][i] >= den) begin
                  dv_rem_ff[g+1][i] <= dv_rem_ff[g][i] - den;
                  dv_q_ff[g+1][i]   <= dv_q_ff[g][i] | QBIT;
               end else begin
                  dv_rem_ff[g+1][i] <= dv_rem_ff[g][i];
                  dv_q_ff[g+1][i]   <= dv_q_ff[g][i];
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- shift lines
   always_ff @(posedge clock) begin
      if (en) begin
         pe_ff[0] <= pe_in;
         for (int k = 1; k <= ST_OUT; k++) pe_ff[k] <= pe_ff[k-1];
         for (int k = ST_LSQ + 1; k < ST_OUT; k++) side_ff[k] <= side_ff[k-1];
         for (int k = ST_CROT + 1; k < ST_OUT; k++) nrm_ff[k] <= nrm_ff[k-1];
      end
   end

   // ---------------------------------------------------------------- output
   side_type           side_end;
   logic signed [19:0] gq [3];
   logic [2:0][18:0]   rot_in;
   logic [2:0][18:0]   rot_ff;
   branch_type         branch_ff;

   assign side_end = side_ff[ST_OUT-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         gq[i] = dv_neg_ff[QW][i] ? -$signed({1'b0, dv_q_ff[QW][i]})
                                  : $signed({1'b0, dv_q_ff[QW][i]});
         case (side_end.branch)
            BR_ALIGNED: rot_in[i] = '0;
            BR_HALF:    rot_in[i] = side_end.rot_half[i];
            default: begin
               if (gq[i][19] != gq[i][18]) begin
                  rot_in[i] = gq[i][19] ? 19'h40000 : 19'h3ffff;
               end else begin
                  rot_in[i] = gq[i][18:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff    <= rot_in;
         branch_ff <= side_end.branch;
      end
   end

   assign rsp_tdata = {7'd0, rot_ff[2], rot_ff[1], rot_ff[0],
                       pe_ff[ST_OUT][2], pe_ff[ST_OUT][1], pe_ff[ST_OUT][0]};
   assign rsp_tuser = branch_ff;

   // ---------------------------------------------------------------- checks
   `PAE_ASSERT_NXT(a_stall_freeze, !en, $stable(vld_ff), "pipe moved while stalled")
   `PAE_ASSERT_IMP(a_aligned_zero, rsp_tvalid && (branch_ff == BR_ALIGNED),
      rot_ff == '0, "aligned case with nonzero rotation error")
   `PAE_ASSERT_IMP(a_norm_nonzero, vld_ff[ST_MAG] && (side_ff[ST_MAG].branch == BR_GENERAL),
      nrm_ff[ST_MAG] != '0, "general case with zero norm")
   `PAE_ASSERT_IMP(a_div_rem, vld_ff[ST_OUT-1] && (side_end.branch == BR_GENERAL),
      (dv_rem_ff[QW][0] < DV_W'(nrm_ff[ST_OUT-1])) &&
      (dv_rem_ff[QW][1] < DV_W'(nrm_ff[ST_OUT-1])) &&
      (dv_rem_ff[QW][2] < DV_W'(nrm_ff[ST_OUT-1])), "quotient overflowed divider")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for pose_angle_axis_error: streams current poses, predicts each error beat.
// Depends on pae_pkg and the block's RTL; nothing else.

module testbench;
   import pae_pkg::*;

   localparam int ONE = 1 << FRAC;
   localparam int LIMIT = 400000;
   localparam int TAIL = 120;
   localparam logic [2:0] REG_UNMAPPED = 3'd6;
   localparam longint ROT_HI = 262143;
   localparam longint ROT_LO = -262144;

   typedef struct {
      logic signed [17:0] rc[9];
      logic signed [31:0] p[3];
   } pose_type;

   typedef struct {
      logic signed [31:0] pos[3];
      logic signed [18:0] rot[3];
      branch_type br;
   } pose_err_type;

   class pose_err_board;
      logic signed [17:0] trot[3][3];
      logic signed [31:0] tpos[3];
      pose_err_type pending_q[$];
      longint atan_tab[FRAC + 8];
      int errors;
      int seen[3];

      function new();
         longint sum;
         int d;
         for (int i = 0; i < FRAC + 8; i++) begin
            sum = 0;
            if (i == 0) sum = PI_Q61 >>> 2;
            else
               for (int k = 0; k < 32; k++) begin
                  d = i * (2 * k + 1);
                  if (d <= 61)
                     sum += ((k % 2) ? -1 : 1) * ((64'sd1 << (61 - d)) / (2 * k + 1));
               end
            atan_tab[i] = sum;
         end
         errors = 0;
         seen = '{0, 0, 0};
         for (int i = 0; i < 3; i++) begin
            tpos[i] = 0;
            for (int j = 0; j < 3; j++) trot[i][j] = (i == j) ? ONE : 0;
         end
      endfunction

      function void write_reg(logic [2:0] idx, logic [53:0] v);
         if (idx <= REG_ROT_ROW2)
            for (int j = 0; j < 3; j++) trot[idx][j] = v[36 - 18 * j +: 18];
         else if (idx <= REG_POS_Z) tpos[idx - REG_POS_X] = v[31:0];
      endfunction

      function longint round_shr(longint v, int s);
         return (v + (64'sd1 << (s - 1))) >>> s;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return r;
      endfunction

      // Vectoring CORDIC, y > 0; pre-rotate by pi/2 when x is negative.
      function longint angle_of(longint x, longint y);
         longint z, t, xs, ys;
         z = 0;
         if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = PI_Q61 >>> 1;
         end
         for (int i = 0; i < FRAC + 8; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x += ys;
               y -= xs;
               z += atan_tab[i];
            end else begin
               x -= ys;
               y += xs;
               z -= atan_tab[i];
            end
         end
         return z;
      endfunction

      // Round to nearest, ties away from zero.
      function longint div_near(longint p, longint n);
         longint unsigned mag, q;
         if (n <= 0) return 0;
         mag = p < 0 ? -p : p;
         q = (mag + n / 2) / n;
         return p < 0 ? -longint'(q) : longint'(q);
      endfunction

      function void note_pose(pose_type q);
         longint r[3][3], l[3], s, tr, nrm, z, ang;
         longint unsigned lsq, thr;
         pose_err_type w;
         for (int i = 0; i < 3; i++)
            w.pos[i] = clip(longint'(tpos[i]) - longint'(q.p[i]), -(64'sd1 << 31),
                            (64'sd1 << 31) - 1);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               s = 0;
               for (int k = 0; k < 3; k++) s += longint'(trot[i][k]) * longint'(q.rc[3 * j + k]);
               r[i][j] = round_shr(s, FRAC);
            end
         l[0] = r[2][1] - r[1][2];
         l[1] = r[0][2] - r[2][0];
         l[2] = r[1][0] - r[0][1];
         lsq = l[0] * l[0] + l[1] * l[1] + l[2] * l[2];
         tr = r[0][0] + r[1][1] + r[2][2];
         thr = ((64'd1 << (2 * FRAC)) + 64'd1000000000000 - 1) / 64'd1000000000000;
         if (lsq < thr) begin
            if (tr > 0) begin
               w.br = BR_ALIGNED;
               w.rot = '{0, 0, 0};
            end else begin
               w.br = BR_HALF;
               for (int i = 0; i < 3; i++)
                  w.rot[i] = clip(round_shr((PI_Q61 >>> (54 - FRAC)) * (r[i][i] + ONE), FRAC + 8),
                                  ROT_LO, ROT_HI);
            end
         end else begin
            w.br = BR_GENERAL;
            nrm = root(lsq << 8);
            z = angle_of((tr - ONE) * 16, nrm);
            ang = round_shr(z, 61 - FRAC - 4);
            for (int i = 0; i < 3; i++)
               w.rot[i] = clip(div_near(ang * l[i], nrm), ROT_LO, ROT_HI);
         end
         pending_q.push_back(w);
      endfunction

      function void check_result(logic [159:0] d, logic [1:0] u);
         pose_err_type w;
         if (pending_q.size() == 0) begin
            $error("error beat with nothing pending: data %h user %0d", d, u);
            errors++;
            return;
         end
         w = pending_q.pop_front();
         seen[w.br]++;
         for (int i = 0; i < 3; i++) begin
            if (d[32 * i +: 32] !== w.pos[i]) begin
               $error("pos_err[%0d]: expected %0d actual %0d", i, w.pos[i],
                      $signed(d[32 * i +: 32]));
               errors++;
            end
            if (d[96 + 19 * i +: 19] !== w.rot[i]) begin
               $error("rot_err[%0d]: expected %0d actual %0d", i, w.rot[i],
                      $signed(d[96 + 19 * i +: 19]));
               errors++;
            end
         end
         if (u !== w.br) begin
            $error("branch_taken: expected %0d actual %0d", w.br, u);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [2:0] csr_addr = '0;
   logic [53:0] csr_wdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [263:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [159:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   pose_err_board board = new();
   int cycles = 0;
   int poses_sent = 0;
   bit send_idle = 1;
   bit take_idle = 1;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   pose_angle_axis_error u_dut (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   // Hang guard: generous against the slowest legal run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Score every beat the sink takes.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);

   // Sink: stall a random number of cycles before each beat, or none in a burst stretch.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = take_idle ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Register writes go in between beats only, with the pipe drained.
   task automatic write_csr(logic [2:0] idx, logic [53:0] v);
      csr_we = 1;
      csr_addr = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 0;
      board.write_reg(idx, v);
   endtask

   task automatic send_pose(pose_type q);
      int gap;
      gap = send_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      for (int k = 0; k < 9; k++) req_tdata[18 * k +: 18] = q.rc[k];
      for (int k = 0; k < 3; k++) req_tdata[162 + 32 * k +: 32] = q.p[k];
      req_tdata[263:258] = '0;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      board.note_pose(q);
      poses_sent++;
      @(negedge clock);
   endtask

   // Hold off until every pending beat is back.
   task automatic drain();
      req_tvalid = 0;
      while (board.pending_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [17:0] pick18(int kind);
      case (kind)
         0: return 18'sh1FFFF;
         1: return 18'sh20000;
         2: return 0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] pick32(int kind);
      case (kind)
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 0;
         default: return $urandom;
      endcase
   endfunction

   function automatic pose_type mk(int m[9], int x, int y, int z);
      pose_type q;
      for (int k = 0; k < 9; k++) q.rc[k] = m[k];
      q.p = '{x, y, z};
      return q;
   endfunction

   // Mix of raw noise, diagonal-only matrices (skew often zero), near-identity
   // rotations and per-field extremes.
   function automatic pose_type random_pose();
      pose_type q;
      int kind;
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) begin
         if (kind <= 4) q.rc[k] = $urandom;
         else if (kind <= 6) q.rc[k] = (k % 4 == 0) ? 18'($urandom) : 18'sd0;
         else if (kind <= 8)
            q.rc[k] = ((k % 4 == 0) ? ONE : 0) + $signed($urandom_range(0, 2000)) - 1000;
         else q.rc[k] = pick18($urandom_range(0, 3));
      end
      for (int k = 0; k < 3; k++)
         q.p[k] = (kind == 9) ? pick32($urandom_range(0, 3)) : 32'($urandom);
      return q;
   endfunction

   function automatic logic [53:0] pack_row(logic [17:0] c0, logic [17:0] c1, logic [17:0] c2);
      return {c0, c1, c2};
   endfunction

   task automatic random_run(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            send_idle = $urandom_range(0, 3) != 0;
            take_idle = $urandom_range(0, 3) != 0;
         end
         send_pose(random_pose());
      end
   endtask

   initial begin
      int c;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed, under reset target (identity, origin).
      c = 46341;
      send_pose(mk('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 0, 0, 0));           // aligned
      send_pose(mk('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}, 1, -1, ONE));    // half-turn about z
      send_pose(mk('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 5, 6, 7));     // not a rotation, trace < 0
      send_pose(mk('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, 0, 0));               // zero matrix
      send_pose(mk('{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE}, ONE, 0, -ONE));   // quarter turn
      send_pose(mk('{-c, -c, 0, c, -c, 0, 0, 0, ONE}, 0, 0, 0));          // 135 deg, trace - 1 < 0
      send_pose(mk('{-c, c, 0, -c, -c, 0, 0, 0, ONE}, 0, 0, 0));
      send_pose(mk('{131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071},
                   32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
      send_pose(mk('{-131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072,
                     -131072}, 32'sh80000000, 32'sh80000000, 32'sh80000000));
      send_pose(mk('{18'sh15555, 18'sh2AAAA, 18'sh15555, 18'sh2AAAA, 18'sh15555, 18'sh2AAAA,
                     18'sh15555, 18'sh2AAAA, 18'sh15555}, 32'sh55555555, 32'shAAAAAAAA, 1));
      send_pose(mk('{131071, 0, -131072, 0, 131071, 0, 131072, 0, -131072}, -1, 0, 1));
      random_run(100);
      drain();

      // Extreme target: row 0 all ones, rows 1-2 extreme, x/y max, z min; poke unmapped index.
      write_csr(REG_ROT_ROW0, {54{1'b1}});
      write_csr(REG_ROT_ROW1, pack_row(18'h1FFFF, 18'h20000, 18'h1FFFF));
      write_csr(REG_ROT_ROW2, pack_row(18'h20000, 18'h1FFFF, 18'h20000));
      write_csr(REG_POS_X, 54'h7FFFFFFF);
      write_csr(REG_POS_Y, 54'h7FFFFFFF);
      write_csr(REG_POS_Z, 54'h80000000);
      write_csr(REG_UNMAPPED, {54{1'b1}});
      send_pose(mk('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF));
      random_run(120);
      drain();

      // Zero target rotation, bottom position on x and y, top on z.
      write_csr(REG_ROT_ROW0, '0);
      write_csr(REG_ROT_ROW1, '0);
      write_csr(REG_ROT_ROW2, '0);
      write_csr(REG_POS_X, 54'h80000000);
      write_csr(REG_POS_Y, 54'h80000000);
      write_csr(REG_POS_Z, 54'h7FFFFFFF);
      send_pose(mk('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 32'sh7FFFFFFF, 1, -1));
      random_run(80);
      drain();

      // Random targets, two rounds.
      repeat (2) begin
         for (int r = REG_ROT_ROW0; r <= REG_POS_Z; r++)
            write_csr(r, {$urandom, $urandom});
         random_run(100);
         drain();
      end

      // Back to identity with a random x offset.
      write_csr(REG_ROT_ROW0, pack_row(ONE, 0, 0));
      write_csr(REG_ROT_ROW1, pack_row(0, ONE, 0));
      write_csr(REG_ROT_ROW2, pack_row(0, 0, ONE));
      write_csr(REG_POS_X, $urandom);
      random_run(100);
      drain();

      repeat (TAIL) @(negedge clock);
      if (board.pending_q.size() != 0) begin
         $error("%0d error beats never arrived", board.pending_q.size());
         board.errors++;
      end
      $display("tb: %0d poses checked across 6 target settings", poses_sent);
      $display("tb: general %0d, aligned %0d, half-turn %0d", board.seen[BR_GENERAL],
               board.seen[BR_ALIGNED], board.seen[BR_HALF]);
      if (board.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
